// ===== rtl/core/c2v3_pkg.sv =====
// Shared constants and types for the 3x3 valid-region convolution stream block.
// No dependencies; every other file imports this package.
`default_nettype none

package c2v3_pkg;

    localparam int KSIZE      = 3;
    localparam int TAPS       = KSIZE * KSIZE;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = PIX_W + 1 + COEF_W;     // unsigned pixel times signed coef
    localparam int ROWSUM_W   = PROD_W + 2;             // three products
    localparam int SUM_W      = 28;                     // nine products, exact

    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int CFG_DATA_W = KSIZE * COEF_W;
    localparam int CFG_IDX_W  = 3;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_TOP = 3'd2,
        REG_COEF_MID = 3'd3,
        REG_COEF_BOTTOM = 3'd4
    } c2v3_reg_idx_t;

    typedef logic [TAPS-1:0][COEF_W-1:0] c2v3_coefs_t;

    // Window handed from the line buffer to the multiply-accumulate stages.
    typedef struct packed {
        logic                       valid;
        logic                       emit;
        logic                       last;
        logic [TAPS-1:0][PIX_W-1:0] win;
    } c2v3_win_t;

    // Finished result beat.
    typedef struct packed {
        logic signed [SUM_W-1:0] filtered;
        logic                    frame_end;
    } c2v3_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/c2v3_pix_if.sv =====
// Pixel stream channel: valid/ready handshake with pixel and frame_start payload.
// Depends on c2v3_pkg.
`default_nettype none

interface c2v3_pix_if
    import c2v3_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/c2v3_res_if.sv =====
// Result stream channel: valid/ready handshake with filtered and frame_end payload.
// Depends on c2v3_pkg.
`default_nettype none

interface c2v3_res_if
    import c2v3_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] filtered;
    logic                    frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/c2v3_line_buf.sv =====
// Raster position counters, two line memories and the 3x3 pixel window.
// Depends on c2v3_pkg.
`default_nettype none

module c2v3_line_buf
    import c2v3_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [PIX_W-1:0] pixel,
    input  wire logic             frame_start,
    input  wire logic [COL_W-1:0] col_last,
    input  wire logic [ROW_W-1:0] row_last,
    output c2v3_win_t             win_out
);

    logic [PIX_W-1:0] line_a_reg [MAX_WIDTH];  // line one above
    logic [PIX_W-1:0] line_b_reg [MAX_WIDTH];  // line two above

    logic [COL_W-1:0] col_reg, col_next, col;
    logic [ROW_W-1:0] row_reg, row_next, row;

    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] rd_a_reg, rd_b_reg;
    logic             fwd_reg, fwd_next;
    logic [PIX_W-1:0] fwd_a_reg, fwd_b_reg;
    logic [PIX_W-1:0] up1, up2;

    logic                                   s2_valid_reg;
    logic                                   s2_emit_reg;
    logic                                   s2_last_reg;
    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_reg;

    always_comb
    begin
        col = frame_start ? '0 : col_reg;
        row = frame_start ? '0 : row_reg;
        if (col >= col_last)
        begin
            col_next = '0;
            row_next = (row >= row_last) ? '0 : row + ROW_W'(1);
        end
        else
        begin
            col_next = col + COL_W'(1);
            row_next = row;
        end
    end

    // The previous beat writes its column in the cycle after its read, so a
    // beat reading the same column right behind it takes the values forwarded.
    assign fwd_next = accept && s1_valid_reg && (col == s1_col_reg);
    assign up1      = fwd_reg ? fwd_a_reg : rd_a_reg;
    assign up2      = fwd_reg ? fwd_b_reg : rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_reg      <= fwd_next;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_valid_reg)
            begin
                for (int r = 0; r < KSIZE; r++)
                begin
                    for (int c = 0; c < KSIZE - 1; c++)
                    begin
                        win_reg[r][c] <= win_reg[r][c+1];
                    end
                end
                win_reg[0][KSIZE-1] <= up2;
                win_reg[1][KSIZE-1] <= up1;
                win_reg[2][KSIZE-1] <= s1_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col;
            s1_pix_reg  <= pixel;
            s1_emit_reg <= (row >= ROW_W'(KSIZE - 1)) && (col >= COL_W'(KSIZE - 1));
            s1_last_reg <= (row >= row_last) && (col >= col_last);
            rd_a_reg    <= line_a_reg[col];
            rd_b_reg    <= line_b_reg[col];
        end
        if (s1_valid_reg)
        begin
            line_a_reg[s1_col_reg] <= s1_pix_reg;
            line_b_reg[s1_col_reg] <= up1;
            s2_emit_reg            <= s1_emit_reg;
            s2_last_reg            <= s1_last_reg;
        end
        fwd_a_reg <= s1_pix_reg;
        fwd_b_reg <= up1;
    end

    always_comb
    begin
        win_out.valid = s2_valid_reg;
        win_out.emit  = s2_emit_reg;
        win_out.last  = s2_last_reg;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE; c++)
            begin
                win_out.win[r*KSIZE+c] = win_reg[r][c];
            end
        end
    end

    a_fwd_only_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(accept) && $past(s1_valid_reg))
        else $error("forwarding without two consecutive beats");

    a_s2_follows_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("window stage dropped a beat");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) && !$past(frame_start) && $stable(col_last) |->
            (col_reg <= col_last))
        else $error("column counter beyond line end");

endmodule

`default_nettype wire

// ===== rtl/core/c2v3_mac.sv =====
// Nine pixel-times-coefficient products, three row sums and the final sum.
// Depends on c2v3_pkg.
`default_nettype none

module c2v3_mac
    import c2v3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire c2v3_win_t   win_in,
    input  wire c2v3_coefs_t coefs,
    output logic             done,
    output logic             push,
    output c2v3_res_t        res
);

    logic                           p_valid_reg;
    logic                           p_emit_reg;
    logic                           p_last_reg;
    logic signed [PROD_W-1:0]       prod_reg [TAPS];

    logic                           q_valid_reg;
    logic                           q_emit_reg;
    logic                           q_last_reg;
    logic signed [ROWSUM_W-1:0]     rsum_reg [KSIZE];
    logic signed [ROWSUM_W-1:0]     rsum_next [KSIZE];

    logic                           r_valid_reg;
    logic                           r_emit_reg;
    logic                           r_last_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic signed [SUM_W:0]          sum_next;

    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            rsum_next[r] = ROWSUM_W'(prod_reg[r*KSIZE])
                         + ROWSUM_W'(prod_reg[r*KSIZE+1])
                         + ROWSUM_W'(prod_reg[r*KSIZE+2]);
        end
        sum_next = (SUM_W+1)'(rsum_reg[0]) + (SUM_W+1)'(rsum_reg[1])
                 + (SUM_W+1)'(rsum_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= win_in.valid;
            q_valid_reg <= p_valid_reg;
            r_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_in.valid)
        begin
            p_emit_reg <= win_in.emit;
            p_last_reg <= win_in.last;
            for (int i = 0; i < TAPS; i++)
            begin
                prod_reg[i] <= $signed({1'b0, win_in.win[i]}) * $signed(coefs[i]);
            end
        end
        if (p_valid_reg)
        begin
            q_emit_reg <= p_emit_reg;
            q_last_reg <= p_last_reg;
            for (int r = 0; r < KSIZE; r++)
            begin
                rsum_reg[r] <= rsum_next[r];
            end
        end
        if (q_valid_reg)
        begin
            r_emit_reg <= q_emit_reg;
            r_last_reg <= q_last_reg;
            sum_reg    <= sum_next[SUM_W-1:0];
        end
    end

    assign done          = r_valid_reg;
    assign push          = r_valid_reg && r_emit_reg;
    assign res.filtered  = sum_reg;
    assign res.frame_end = r_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/c2v3_res_fifo.sv =====
// Small result queue between the arithmetic pipeline and the output channel.
// Depends on c2v3_pkg.
`default_nettype none

module c2v3_res_fifo
    import c2v3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire c2v3_res_t             push_data,
    input  wire logic                  pop,
    output c2v3_res_t                  head,
    output logic [FIFO_CNT_W-1:0]      count
);

    c2v3_res_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/conv2d_valid_3x3_stream.sv =====
// Top level of the 3x3 valid-region convolution over a raster pixel stream.
// Depends on c2v3_pkg, c2v3_pix_if, c2v3_res_if, c2v3_line_buf, c2v3_mac, c2v3_res_fifo.
//
//   channel   dir  payload                         accepted when
//   pixels    in   pixel[7:0], frame_start         pixels.valid && pixels.ready
//   results   out  filtered[27:0] signed, frame_end results.valid && results.ready
//   cfg       in   cfg_index[2:0], cfg_data[47:0]  cfg_we
//
// One pixel per cycle while pixels.ready holds; each result passes the window, product,
// row-sum and sum registers, then the result queue. The line memories are read on the
// accept edge and written in the following cycle. An 8-entry result queue absorbs
// output stalls; pixels.ready drops once the beats in flight plus the queued results would fill it.
// Reset clears counters, window and queue; line memories hold no reset value.
`default_nettype none

module conv2d_valid_3x3_stream
    import c2v3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    c2v3_pix_if.sink                   pixels,
    c2v3_res_if.source                 results,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [IMG_W_W-1:0]    image_width_reg;
    logic [IMG_H_W-1:0]    image_height_reg;
    logic [CFG_DATA_W-1:0] coef_row_reg [KSIZE];

    logic [COL_W-1:0]      col_last;
    logic [ROW_W-1:0]      row_last;
    c2v3_coefs_t           coefs;
    logic                  accept;
    c2v3_win_t             win;
    logic                  done;
    logic                  push;
    c2v3_res_t             res;
    c2v3_res_t             head;
    logic [FIFO_CNT_W-1:0] count;
    logic [FIFO_CNT_W-1:0] pending_reg;
    logic [FIFO_CNT_W:0]   occupancy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_W'(640);
            image_height_reg <= IMG_H_W'(480);
            for (int r = 0; r < KSIZE; r++)
            begin
                coef_row_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_W-1:0];
                REG_COEF_TOP:     coef_row_reg[0]  <= cfg_data;
                REG_COEF_MID:     coef_row_reg[1]  <= cfg_data;
                REG_COEF_BOTTOM:  coef_row_reg[2]  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Line and frame lengths in use, clamped between the window size and what the buffers support.
    always_comb
    begin
        if (image_width_reg < IMG_W_W'(KSIZE))
            col_last = COL_W'(KSIZE - 1);
        else if (int'(image_width_reg) > MAX_WIDTH)
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(image_width_reg - IMG_W_W'(1));

        if (image_height_reg < IMG_H_W'(KSIZE))
            row_last = ROW_W'(KSIZE - 1);
        else if (int'(image_height_reg) > MAX_HEIGHT)
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(image_height_reg - IMG_H_W'(1));

        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE; c++)
            begin
                coefs[r*KSIZE+c] = coef_row_reg[r][c*COEF_W +: COEF_W];
            end
        end
    end

    // Every beat in flight holds a queue slot until it retires.
    assign occupancy     = {1'b0, pending_reg} + {1'b0, count};
    assign pixels.ready  = occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign accept        = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (accept && !done)
        begin
            pending_reg <= pending_reg + FIFO_CNT_W'(1);
        end
        else if (!accept && done)
        begin
            pending_reg <= pending_reg - FIFO_CNT_W'(1);
        end
    end

    c2v3_line_buf u_line_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (pixels.pixel),
        .frame_start (pixels.frame_start),
        .col_last    (col_last),
        .row_last    (row_last),
        .win_out     (win)
    );

    c2v3_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .win_in (win),
        .coefs  (coefs),
        .done   (done),
        .push   (push),
        .res    (res)
    );

    c2v3_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .pop       (results.ready),
        .head      (head),
        .count     (count)
    );

    assign results.valid     = (count != '0);
    assign results.filtered  = head.filtered;
    assign results.frame_end = head.frame_end;

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count < FIFO_CNT_W'(FIFO_DEPTH)) || results.ready)
        else $error("result queue overflow");

    a_pipeline_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= FIFO_CNT_W'(5))
        else $error("more beats in flight than pipeline stages");

    a_retire_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("beat retired without matching accept");

endmodule

`default_nettype wire
